FILE: rtl/tvfr_pkg.sv
// Shared constants and types for the typed value frame receiver.
// No dependencies; used by typed_value_frame_receiver_unit.
package tvfr_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned ValueW = 64;
    localparam int unsigned CountW = 4;

    // Tag bytes that open a frame, and the terminator.
    localparam logic [ByteW-1:0] TAG_BOOL   = 8'd100;
    localparam logic [ByteW-1:0] TAG_INT    = 8'd101;
    localparam logic [ByteW-1:0] TAG_FLOAT  = 8'd102;
    localparam logic [ByteW-1:0] TAG_DOUBLE = 8'd103;
    localparam logic [ByteW-1:0] FRAME_END  = 8'd10;

    // Payload lengths in bytes.
    localparam logic [CountW-1:0] LEN_BOOL   = 4'd1;
    localparam logic [CountW-1:0] LEN_WORD   = 4'd4;
    localparam logic [CountW-1:0] LEN_DOUBLE = 4'd8;

    typedef enum logic [1:0] {
        KIND_BOOL   = 2'd0,
        KIND_INT    = 2'd1,
        KIND_FLOAT  = 2'd2,
        KIND_DOUBLE = 2'd3
    } t_value_kind;

endpackage

FILE: rtl/typed_value_frame_receiver_unit.sv
// Typed value frame receiver: byte-stream frame parser with registered result.
// Depends on tvfr_pkg.
//
// The registered result reaches the master side in the cycle after the terminator beat.
// Throughput: one byte beat per cycle while no held result stalls the slave side.
// A held result stalls the slave side only until it is taken (output register).
// Reset (synchronous, active low) returns the parser to idle and drops o_m_tvalid.
module typed_value_frame_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: received bytes
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    // master side: decoded values
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [63:0] raw_value
    output logic [1:0]  o_m_tuser    // [1:0] value_kind
);

    // Parser state
    logic                           r_receiving, n_receiving;
    tvfr_pkg::t_value_kind          r_kind, n_kind;
    logic [tvfr_pkg::CountW-1:0]    r_expected, n_expected;
    logic [tvfr_pkg::CountW-1:0]    r_count, n_count;
    // Payload bytes shift in from the low end, so the low bits always hold
    // the most recent bytes in big-endian order.
    logic [tvfr_pkg::ValueW-1:0]    r_shift, n_shift;

    // Result register
    logic                           r_out_valid, n_out_valid;
    logic [tvfr_pkg::ValueW-1:0]    r_out_value, n_out_value;
    tvfr_pkg::t_value_kind          r_out_kind, n_out_kind;

    logic                           s_accept;
    logic                           emit;
    logic [tvfr_pkg::ValueW-1:0]    frame_value;

    // Free to take a beat unless a result is waiting and not being taken.
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Value for the frame currently held, used only on the terminator beat.
    always_comb begin
        unique case (r_kind)
            tvfr_pkg::KIND_BOOL: begin
                frame_value = {{(tvfr_pkg::ValueW-1){1'b0}}, (r_shift[7:0] == 8'd1)};
            end
            tvfr_pkg::KIND_INT, tvfr_pkg::KIND_FLOAT: begin
                frame_value = {32'd0, r_shift[31:0]};
            end
            tvfr_pkg::KIND_DOUBLE: begin
                frame_value = r_shift;
            end
            default: begin
                frame_value = r_shift;
            end
        endcase
    end

    // Parser next state
    always_comb begin
        n_receiving = r_receiving;
        n_kind      = r_kind;
        n_expected  = r_expected;
        n_count     = r_count;
        n_shift     = r_shift;
        emit        = 1'b0;
        if (s_accept) begin
            if (!r_receiving) begin
                n_count = '0;
                unique case (i_s_tdata)
                    tvfr_pkg::TAG_BOOL: begin
                        n_receiving = 1'b1;
                        n_kind      = tvfr_pkg::KIND_BOOL;
                        n_expected  = tvfr_pkg::LEN_BOOL;
                    end
                    tvfr_pkg::TAG_INT: begin
                        n_receiving = 1'b1;
                        n_kind      = tvfr_pkg::KIND_INT;
                        n_expected  = tvfr_pkg::LEN_WORD;
                    end
                    tvfr_pkg::TAG_FLOAT: begin
                        n_receiving = 1'b1;
                        n_kind      = tvfr_pkg::KIND_FLOAT;
                        n_expected  = tvfr_pkg::LEN_WORD;
                    end
                    tvfr_pkg::TAG_DOUBLE: begin
                        n_receiving = 1'b1;
                        n_kind      = tvfr_pkg::KIND_DOUBLE;
                        n_expected  = tvfr_pkg::LEN_DOUBLE;
                    end
                    default: begin
                        // not a tag: ignored while idle
                        n_count = r_count;
                    end
                endcase
            end else if (r_count >= r_expected) begin
                // payload complete: terminator emits, anything else aborts
                emit        = (i_s_tdata == tvfr_pkg::FRAME_END);
                n_receiving = 1'b0;
                n_kind      = tvfr_pkg::KIND_BOOL;
                n_expected  = '0;
                n_count     = '0;
            end else begin
                n_shift = {r_shift[tvfr_pkg::ValueW-tvfr_pkg::ByteW-1:0], i_s_tdata};
                n_count = r_count + 1'b1;
            end
        end
    end

    // Result register next state
    always_comb begin
        n_out_value = r_out_value;
        n_out_kind  = r_out_kind;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_value = frame_value;
            n_out_kind  = r_kind;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving <= 1'b0;
            r_kind      <= tvfr_pkg::KIND_BOOL;
            r_expected  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_receiving <= n_receiving;
            r_kind      <= n_kind;
            r_expected  <= n_expected;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_shift     <= n_shift;
        r_out_value <= n_out_value;
        r_out_kind  <= n_out_kind;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_value;
    assign o_m_tuser  = r_out_kind;

`ifndef SYNTH
    // byte count never runs past the frame length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_receiving |-> (r_count <= r_expected))
        else $error("byte count beyond expected length");

    // idle parser holds no partial count
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_receiving |-> (r_count == '0))
        else $error("count not cleared while idle");

    // a new result only follows an accepted terminator beat
    a_emit_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |->
            $past(i_s_tvalid && o_s_tready && (i_s_tdata == tvfr_pkg::FRAME_END)))
        else $error("result without terminator");

    // bool result is 0 or 1
    a_bool_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == tvfr_pkg::KIND_BOOL)) |-> (o_m_tdata[63:1] == '0))
        else $error("bool value out of range");

    // 32-bit kinds are zero-extended
    a_word_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && ((o_m_tuser == tvfr_pkg::KIND_INT) ||
                        (o_m_tuser == tvfr_pkg::KIND_FLOAT))) |-> (o_m_tdata[63:32] == '0))
        else $error("32-bit value not zero-extended");
`endif

endmodule

FILE: tb/tb_typed_value_frame_receiver_unit.sv
// Self-checking testbench for typed_value_frame_receiver_unit: directed frames, then random
// well-formed and broken frames under sender gaps and receiver stalls. Depends on tvfr_pkg.
module tb_typed_value_frame_receiver_unit;

    localparam int DirRows   = 28;
    localparam int PhaseBeat = 313;     // counted byte beats per random phase
    localparam int MaxShown  = 10;

    // One decoded value as it leaves the master side.
    typedef struct packed {
        tvfr_pkg::t_value_kind kind;
        logic [63:0]           raw;
    } t_decoded;

    // Directed row: the byte, and a hand-written value where the row closes a frame.
    typedef struct packed {
        logic [7:0] rx;
        bit         typed;
        t_decoded   want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;     // [7:0] rx_byte
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [63:0] o_m_tdata;     // [63:0] raw_value
    logic [1:0]  o_m_tuser;     // [1:0] value_kind

    typed_value_frame_receiver_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Directed frames. Typed rows carry the value read straight off the frame.
    t_stim_row dir_rows [DirRows] = '{
        // bool 1
        '{tvfr_pkg::TAG_BOOL,   1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{8'h01,                1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{tvfr_pkg::FRAME_END,  1'b1, '{tvfr_pkg::KIND_BOOL, 64'd1}},
        // bool with payload neither 0 nor 1 decodes to 0
        '{tvfr_pkg::TAG_BOOL,   1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{8'hC8,                1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{tvfr_pkg::FRAME_END,  1'b1, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        // int, all ones, closed by a tag value: aborted, and the tag opens nothing
        '{tvfr_pkg::TAG_INT,    1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{8'hFF,                1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{8'hFF,                1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{8'hFF,                1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{8'hFF,                1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{tvfr_pkg::TAG_FLOAT,  1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        // float whose payload holds a terminator and a tag value
        '{tvfr_pkg::TAG_FLOAT,  1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{tvfr_pkg::FRAME_END,  1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{tvfr_pkg::TAG_BOOL,   1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{8'h00,                1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{8'h80,                1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{tvfr_pkg::FRAME_END,  1'b1, '{tvfr_pkg::KIND_FLOAT, 64'h0000_0000_0A64_0080}},
        // double, big-endian assembly over all eight bytes
        '{tvfr_pkg::TAG_DOUBLE, 1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{8'hFF,                1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{8'h00,                1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{8'h0A,                1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{tvfr_pkg::TAG_DOUBLE, 1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{8'h01,                1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{8'h80,                1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{8'hFE,                1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{tvfr_pkg::TAG_INT,    1'b0, '{tvfr_pkg::KIND_BOOL, 64'd0}},
        '{tvfr_pkg::FRAME_END,  1'b1, '{tvfr_pkg::KIND_DOUBLE, 64'hFF00_0A67_0180_FE65}}
    };

    // Bytes that matter to the parser, mixed into random payloads.
    logic [7:0] odd_bytes [5] = '{tvfr_pkg::FRAME_END, tvfr_pkg::TAG_BOOL, tvfr_pkg::TAG_INT,
                                  tvfr_pkg::TAG_FLOAT, tvfr_pkg::TAG_DOUBLE};

    // Parser mirror, starts idle as after reset.
    bit                          frm_open = 1'b0;
    tvfr_pkg::t_value_kind       frm_kind = tvfr_pkg::KIND_BOOL;
    logic [tvfr_pkg::CountW-1:0] frm_len = '0;
    logic [tvfr_pkg::CountW-1:0] frm_cnt = '0;
    logic [7:0]                  frm_buf [8];

    t_decoded   decoded_q [$];
    bit         row_typed;
    t_decoded   row_want;
    int         src_idle_pct = 0;
    int         snk_idle_pct = 0;
    int         n_err = 0;
    int         n_beats = 0;
    int         n_values = 0;
    int         n_aborts = 0;
    int         n_kind [4] = '{0, 0, 0, 0};

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("timeout: %0d values still awaited", decoded_q.size());
        $display("tb_typed_value_frame_receiver_unit failed");
        $finish;
    end

    // Advance the mirror by one accepted byte; done is set when a frame closes cleanly.
    task automatic decode_byte(input logic [7:0] rx, output bit done, output t_decoded res);
        logic [63:0] acc;
        int i;
        done = 1'b0;
        res  = '0;
        acc  = '0;
        if (!frm_open) begin
            frm_open = 1'b1;
            frm_cnt  = '0;
            case (rx)
                tvfr_pkg::TAG_BOOL: begin
                    frm_kind = tvfr_pkg::KIND_BOOL;
                    frm_len  = tvfr_pkg::LEN_BOOL;
                end
                tvfr_pkg::TAG_INT: begin
                    frm_kind = tvfr_pkg::KIND_INT;
                    frm_len  = tvfr_pkg::LEN_WORD;
                end
                tvfr_pkg::TAG_FLOAT: begin
                    frm_kind = tvfr_pkg::KIND_FLOAT;
                    frm_len  = tvfr_pkg::LEN_WORD;
                end
                tvfr_pkg::TAG_DOUBLE: begin
                    frm_kind = tvfr_pkg::KIND_DOUBLE;
                    frm_len  = tvfr_pkg::LEN_DOUBLE;
                end
                default: frm_open = 1'b0;
            endcase
        end else if (frm_cnt >= frm_len) begin
            if (rx == tvfr_pkg::FRAME_END) begin
                for (i = 0; i < 8; i++) begin
                    if (i < frm_len) acc = {acc[55:0], frm_buf[i]};
                end
                done     = 1'b1;
                res.kind = frm_kind;
                res.raw  = (frm_kind == tvfr_pkg::KIND_BOOL) ?
                           {63'd0, frm_buf[0] == 8'd1} : acc;
            end else begin
                n_aborts++;
            end
            frm_open = 1'b0;
            frm_kind = tvfr_pkg::KIND_BOOL;
            frm_len  = '0;
            frm_cnt  = '0;
        end else begin
            frm_buf[frm_cnt[2:0]] = rx;
            frm_cnt = frm_cnt + 1'b1;
        end
    endtask

    // One byte beat, with a random gap ahead of it; returns at the accepting edge.
    task automatic send_byte(input logic [7:0] rx, input bit typed, input t_decoded want);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= rx;
        row_typed  <= typed;
        row_want   <= want;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Receiver side: random stalls at the phase's rate.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // Predict on every accepted byte, then check every accepted value in order.
    always @(posedge i_clk) begin
        bit       done;
        t_decoded res;
        t_decoded want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                n_beats++;
                decode_byte(i_s_tdata, done, res);
                if (done || row_typed) decoded_q.push_back(row_typed ? row_want : res);
            end
            if (o_m_tvalid && i_m_tready) begin
                if (decoded_q.size() == 0) begin
                    n_err++;
                    if (n_err <= MaxShown)
                        $display("unexpected value: kind %0d raw %h", o_m_tuser, o_m_tdata);
                end else begin
                    want = decoded_q.pop_front();
                    n_values++;
                    n_kind[want.kind]++;
                    if (want.kind !== o_m_tuser || want.raw !== o_m_tdata) begin
                        n_err++;
                        if (n_err <= MaxShown)
                            $display("mismatch: kind %0d raw %h, expected kind %0d raw %h",
                                     o_m_tuser, o_m_tdata, want.kind, want.raw);
                    end
                end
            end
        end
    end

    initial begin
        int         ph;
        int         k;
        int         sel;
        int         n_ph;
        logic [7:0] rx;
        logic [7:0] tag;
        logic [3:0] len;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        row_typed  <= 1'b0;
        row_want   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling.
        for (k = 0; k < DirRows; k++)
            send_byte(dir_rows[k].rx, dir_rows[k].typed, dir_rows[k].want);

        // Random part: free flow, sender gaps, receiver stalls, then both.
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
                1: begin
                    src_idle_pct = 46;
                    snk_idle_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 46;
                end
                default: begin
                    src_idle_pct = 23;
                    snk_idle_pct = 23;
                end
            endcase
            n_ph = 0;
            while (n_ph < PhaseBeat) begin
                sel = $urandom_range(0, 99);
                if (sel < 8) begin
                    // idle noise; tag values are swapped for a terminator, ignored when idle
                    rx = 8'($urandom_range(0, 255));
                    if (rx >= tvfr_pkg::TAG_BOOL && rx <= tvfr_pkg::TAG_DOUBLE)
                        rx = tvfr_pkg::FRAME_END;
                    send_byte(rx, 1'b0, '0);
                end else begin
                    case ($urandom_range(0, 3))
                        0: begin
                            tag = tvfr_pkg::TAG_BOOL;
                            len = tvfr_pkg::LEN_BOOL;
                        end
                        1: begin
                            tag = tvfr_pkg::TAG_INT;
                            len = tvfr_pkg::LEN_WORD;
                        end
                        2: begin
                            tag = tvfr_pkg::TAG_FLOAT;
                            len = tvfr_pkg::LEN_WORD;
                        end
                        default: begin
                            tag = tvfr_pkg::TAG_DOUBLE;
                            len = tvfr_pkg::LEN_DOUBLE;
                        end
                    endcase
                    send_byte(tag, 1'b0, '0);
                    for (k = 0; k < len; k++) begin
                        if (tag == tvfr_pkg::TAG_BOOL && $urandom_range(0, 2) != 0)
                            rx = 8'($urandom_range(0, 1));
                        else if ($urandom_range(0, 7) == 0)
                            rx = odd_bytes[$urandom_range(0, 4)];
                        else
                            rx = 8'($urandom_range(0, 255));
                        send_byte(rx, 1'b0, '0);
                    end
                    // about one frame in eight ends on a wrong terminator
                    rx = tvfr_pkg::FRAME_END;
                    if (sel < 19) begin
                        rx = 8'($urandom_range(0, 255));
                        if (rx == tvfr_pkg::FRAME_END) rx = odd_bytes[$urandom_range(1, 4)];
                    end
                    send_byte(rx, 1'b0, '0);
                    n_ph += len + 2;
                end
            end
        end
        i_s_tvalid <= 1'b0;

        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d byte beats, %0d values checked (bool %0d int %0d float %0d double %0d)",
                 n_beats, n_values, n_kind[0], n_kind[1], n_kind[2], n_kind[3]);
        $display("%0d frames aborted on a wrong terminator, %0d mismatches", n_aborts, n_err);
        if (n_err == 0) begin
            $display("tb_typed_value_frame_receiver_unit passed");
        end else begin
            $display("tb_typed_value_frame_receiver_unit failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/tvfr_pkg.sv
rtl/typed_value_frame_receiver_unit.sv
tb/tb_typed_value_frame_receiver_unit.sv
